[rtl/core/hypergraph_clique_check_macros.svh]
// Assertion macros shared by the clique check block.
`ifndef HYPERGRAPH_CLIQUE_CHECK_MACROS_SVH
`define HYPERGRAPH_CLIQUE_CHECK_MACROS_SVH

`ifndef SYNTHESIS

`define HCC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define HCC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define HCC_ASSERT_IMP(lbl, ante, cons, msg)

`define HCC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/core/hcc_pkg.sv]
// Types, codes and fixed constants of the hypergraph clique check block.
package hcc_pkg;

	localparam int VERT_W     = 6;
	localparam int PAIR_AW    = 2 * VERT_W;
	localparam int PAIR_DEPTH = 1 << PAIR_AW;
	localparam int SIZE_W     = 6;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_PUSH = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_DROP     = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic              func;
		logic [VERT_W-1:0] vert_a;
		logic [VERT_W-1:0] vert_b;
		logic [VERT_W-1:0] vert_c;
		logic              last;
	} in_t;

	typedef struct packed {
		status_t           status;
		logic              is_clique;
		logic [SIZE_W-1:0] set_size;
	} out_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOAD_WR,
		S_CK_START,
		S_CK_LI,
		S_CK_PAIR,
		S_CK_BKT,
		S_CK_RK,
		S_CK_SCAN
	} state_t;

	typedef enum logic [2:0] {
		RD_ZERO,
		RD_J,
		RD_IP1,
		RD_JP1,
		RD_KP1
	} rd_sel_t;

	typedef enum logic [1:0] {
		RES_DROP,
		RES_OVF,
		RES_PASS,
		RES_FAIL
	} res_kind_t;

	typedef struct packed {
		logic      clr_wr;
		logic      load_rd;
		logic      load_wr;
		logic      push;
		logic      list_clear;
		logic      ck_init;
		logic      ci_latch;
		logic      i_next;
		logic      j_next;
		logic      pair_rd;
		logic      bkt_init;
		logic      k_next;
		logic      ck_latch;
		logic      scan_rd;
		logic      cand_re;
		rd_sel_t   rd_sel;
		logic      res_valid;
		res_kind_t res_kind;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
		logic is_load;
		logic in_range;
		logic store_full;
		logic is_last;
		logic list_over;
		logic set_small;
		logic bkt_ok;
		logic l_lt_m;
		logic hit;
		logic k_last;
		logic j_more;
		logic i_more;
	} sts_t;

endpackage

[rtl/core/hcc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module hcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/hcc_ctrl.sv]
// Controller state machine: sequences loads, pushes and the bucket scan.
module hcc_ctrl
	import hcc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == S_IDLE) && sts.out_free;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (sts.is_load) begin
						if (sts.in_range && !sts.store_full) begin
							state_d = S_LOAD_WR;
						end
					end else if (sts.is_last && !sts.list_over && !sts.set_small) begin
						state_d = S_CK_START;
					end
				end
			end
			S_LOAD_WR:  state_d = S_IDLE;
			S_CK_START: state_d = S_CK_LI;
			S_CK_LI:    state_d = S_CK_PAIR;
			S_CK_PAIR:  state_d = S_CK_BKT;
			S_CK_BKT: begin
				state_d = sts.bkt_ok ? S_CK_RK : S_IDLE;
			end
			S_CK_RK: begin
				state_d = sts.l_lt_m ? S_CK_SCAN : S_IDLE;
			end
			S_CK_SCAN: begin
				if (sts.hit) begin
					if (!sts.k_last) begin
						state_d = S_CK_RK;
					end else if (sts.j_more) begin
						state_d = S_CK_PAIR;
					end else if (sts.i_more) begin
						state_d = S_CK_LI;
					end else begin
						state_d = S_IDLE;
					end
				end else if (!sts.l_lt_m) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd          = '0;
		cmd.rd_sel   = RD_ZERO;
		cmd.res_kind = RES_PASS;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			S_IDLE: begin
				if (accept) begin
					if (sts.is_load) begin
						if (sts.in_range) begin
							if (sts.store_full) begin
								cmd.res_valid = 1'b1;
								cmd.res_kind  = RES_DROP;
							end else begin
								cmd.load_rd = 1'b1;
							end
						end
					end else begin
						cmd.push = 1'b1;
						if (sts.is_last) begin
							if (sts.list_over) begin
								cmd.res_valid  = 1'b1;
								cmd.res_kind   = RES_OVF;
								cmd.list_clear = 1'b1;
							end else if (sts.set_small) begin
								cmd.res_valid  = 1'b1;
								cmd.res_kind   = RES_PASS;
								cmd.list_clear = 1'b1;
							end
						end
					end
				end
			end
			S_LOAD_WR: begin
				cmd.load_wr = 1'b1;
			end
			S_CK_START: begin
				cmd.ck_init = 1'b1;
				cmd.cand_re = 1'b1;
				cmd.rd_sel  = RD_ZERO;
			end
			S_CK_LI: begin
				cmd.ci_latch = 1'b1;
				cmd.cand_re  = 1'b1;
				cmd.rd_sel   = RD_J;
			end
			S_CK_PAIR: begin
				cmd.pair_rd = 1'b1;
			end
			S_CK_BKT: begin
				if (sts.bkt_ok) begin
					cmd.bkt_init = 1'b1;
					cmd.cand_re  = 1'b1;
					cmd.rd_sel   = RD_JP1;
				end else begin
					cmd.res_valid  = 1'b1;
					cmd.res_kind   = RES_FAIL;
					cmd.list_clear = 1'b1;
				end
			end
			S_CK_RK: begin
				cmd.ck_latch = 1'b1;
				if (sts.l_lt_m) begin
					cmd.scan_rd = 1'b1;
				end else begin
					cmd.res_valid  = 1'b1;
					cmd.res_kind   = RES_FAIL;
					cmd.list_clear = 1'b1;
				end
			end
			S_CK_SCAN: begin
				if (sts.hit) begin
					if (!sts.k_last) begin
						cmd.k_next  = 1'b1;
						cmd.cand_re = 1'b1;
						cmd.rd_sel  = RD_KP1;
					end else if (sts.j_more) begin
						cmd.j_next  = 1'b1;
						cmd.cand_re = 1'b1;
						cmd.rd_sel  = RD_JP1;
					end else if (sts.i_more) begin
						cmd.i_next  = 1'b1;
						cmd.cand_re = 1'b1;
						cmd.rd_sel  = RD_IP1;
					end else begin
						cmd.res_valid  = 1'b1;
						cmd.res_kind   = RES_PASS;
						cmd.list_clear = 1'b1;
					end
				end else if (sts.l_lt_m) begin
					cmd.scan_rd = 1'b1;
				end else begin
					cmd.res_valid  = 1'b1;
					cmd.res_kind   = RES_FAIL;
					cmd.list_clear = 1'b1;
				end
			end
			default: begin
				cmd.rd_sel = RD_ZERO;
			end
		endcase
	end

endmodule

[rtl/core/hcc_dpath.sv]
// Datapath: pair table, third-vertex store, candidate list, scan registers
// and the result register.
module hcc_dpath
	import hcc_pkg::*;
#(
	parameter int NUM_VERTICES = 64,
	parameter int MAX_TRIPLES  = 4096,
	parameter int MAX_SET      = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  in_t  in_data,
	input  logic out_ready,
	output logic out_valid,
	output out_t out_data,
	input  cmd_t cmd,
	output sts_t sts
);

	localparam int CW  = $clog2(MAX_TRIPLES + 1);
	localparam int SAW = (MAX_TRIPLES > 1) ? $clog2(MAX_TRIPLES) : 1;
	localparam int NW  = $clog2(MAX_SET + 1);
	localparam int LAW = $clog2(MAX_SET);
	localparam int SW  = (NW > SIZE_W) ? NW : SIZE_W;

	// Pair table word: count in the upper half, offset of first triple below.
	logic [PAIR_AW-1:0] clr_q;
	logic [PAIR_AW-1:0] idx_q;
	logic [CW-1:0]      total_q;
	logic [NW-1:0]      n_q;
	logic               ovf_q;
	logic [NW-1:0]      i_q;
	logic [NW-1:0]      j_q;
	logic [NW-1:0]      k_q;
	logic [VERT_W-1:0]  ci_q;
	logic [VERT_W-1:0]  ck_q;
	logic               rng_q;
	logic [CW-1:0]      l_q;
	logic [CW-1:0]      m_q;
	out_t               out_q;
	logic               out_valid_q;

	logic               pair_we;
	logic [PAIR_AW-1:0] pair_waddr;
	logic [2*CW-1:0]    pair_wdata;
	logic               pair_re;
	logic [PAIR_AW-1:0] pair_raddr;
	logic [2*CW-1:0]    pair_rdata;
	logic [CW-1:0]      pw_cnt;
	logic [CW-1:0]      pw_off;
	logic [CW:0]        bkt_end;
	logic [CW-1:0]      bkt_hi;

	logic [VERT_W-1:0]  store_rdata;
	logic [LAW-1:0]     cand_raddr;
	logic [VERT_W-1:0]  cand_rdata;
	logic               list_full;
	logic               cand_we;

	logic [NW-1:0]      i_p1;
	logic [NW-1:0]      i_p2;
	logic [NW-1:0]      j_p1;
	logic [NW-1:0]      k_p1;
	logic [NW-1:0]      n_eff;
	logic [SW-1:0]      n_wide;
	logic [SIZE_W-1:0]  size_v;
	out_t               res_v;

	assign pw_cnt  = pair_rdata[2*CW-1:CW];
	assign pw_off  = pair_rdata[CW-1:0];
	assign bkt_end = {1'b0, pw_off} + {1'b0, pw_cnt};
	assign bkt_hi  = (bkt_end > {1'b0, total_q}) ? total_q : bkt_end[CW-1:0];

	assign list_full = (n_q == NW'(MAX_SET));
	assign cand_we   = cmd.push && !list_full;

	assign i_p1 = i_q + NW'(1);
	assign i_p2 = i_q + NW'(2);
	assign j_p1 = j_q + NW'(1);
	assign k_p1 = k_q + NW'(1);

	// Pair table write port: the clearing pass owns it until it is done.
	always_comb begin
		pair_we = cmd.clr_wr || cmd.load_wr;
		if (cmd.clr_wr) begin
			pair_waddr = clr_q;
			pair_wdata = '0;
		end else begin
			pair_waddr = idx_q;
			pair_wdata = {pw_cnt + CW'(1), (pw_cnt == '0) ? total_q : pw_off};
		end
	end

	assign pair_re    = cmd.load_rd || cmd.pair_rd;
	assign pair_raddr = cmd.load_rd ? {in_data.vert_a, in_data.vert_b}
	                                : {ci_q, cand_rdata};

	always_comb begin
		unique case (cmd.rd_sel)
			RD_ZERO: cand_raddr = '0;
			RD_J:    cand_raddr = j_q[LAW-1:0];
			RD_IP1:  cand_raddr = i_p1[LAW-1:0];
			RD_JP1:  cand_raddr = j_p1[LAW-1:0];
			RD_KP1:  cand_raddr = k_p1[LAW-1:0];
			default: cand_raddr = '0;
		endcase
	end

	hcc_ram #(
		.WIDTH(2 * CW),
		.DEPTH(PAIR_DEPTH)
	) u_pair_ram (
		.clk  (clk),
		.we   (pair_we),
		.waddr(pair_waddr),
		.wdata(pair_wdata),
		.re   (pair_re),
		.raddr(pair_raddr),
		.rdata(pair_rdata)
	);

	hcc_ram #(
		.WIDTH(VERT_W),
		.DEPTH(MAX_TRIPLES)
	) u_store_ram (
		.clk  (clk),
		.we   (cmd.load_rd),
		.waddr(total_q[SAW-1:0]),
		.wdata(in_data.vert_c),
		.re   (cmd.scan_rd),
		.raddr(l_q[SAW-1:0]),
		.rdata(store_rdata)
	);

	hcc_ram #(
		.WIDTH(VERT_W),
		.DEPTH(MAX_SET)
	) u_cand_ram (
		.clk  (clk),
		.we   (cand_we),
		.waddr(n_q[LAW-1:0]),
		.wdata(in_data.vert_a),
		.re   (cmd.cand_re),
		.raddr(cand_raddr),
		.rdata(cand_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			total_q     <= '0;
			n_q         <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			l_q         <= '0;
			m_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + PAIR_AW'(1);
			end
			if (cmd.load_wr) begin
				total_q <= total_q + CW'(1);
			end
			if (cmd.list_clear) begin
				n_q   <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.push) begin
				if (list_full) begin
					ovf_q <= 1'b1;
				end else begin
					n_q <= n_q + NW'(1);
				end
			end
			if (cmd.ck_init) begin
				i_q <= '0;
				j_q <= NW'(1);
			end else if (cmd.i_next) begin
				i_q <= i_p1;
				j_q <= i_p2;
			end else if (cmd.j_next) begin
				j_q <= j_p1;
			end
			if (cmd.bkt_init) begin
				k_q <= j_p1;
				l_q <= pw_off;
				m_q <= bkt_hi;
			end else begin
				if (cmd.k_next) begin
					k_q <= k_p1;
				end
				if (cmd.scan_rd) begin
					l_q <= l_q + CW'(1);
				end
			end
			if (cmd.res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rd) begin
			idx_q <= {in_data.vert_a, in_data.vert_b};
		end
		if (cmd.ci_latch) begin
			ci_q <= cand_rdata;
		end
		if (cmd.pair_rd) begin
			rng_q <= (32'(ci_q) < 32'(NUM_VERTICES)) && (32'(cand_rdata) < 32'(NUM_VERTICES));
		end
		if (cmd.ck_latch) begin
			ck_q <= cand_rdata;
		end
		if (cmd.res_valid) begin
			out_q <= res_v;
		end
	end

	// The kept count including a vertex pushed in this cycle.
	assign n_eff  = cand_we ? (n_q + NW'(1)) : n_q;
	assign n_wide = SW'(n_eff);
	assign size_v = n_wide[SIZE_W-1:0];

	always_comb begin
		unique case (cmd.res_kind)
			RES_DROP: res_v = '{status: ST_DROP, is_clique: 1'b0, set_size: '0};
			RES_OVF:  res_v = '{status: ST_OVERFLOW, is_clique: 1'b0, set_size: size_v};
			RES_PASS: res_v = '{status: ST_DONE, is_clique: 1'b1, set_size: size_v};
			RES_FAIL: res_v = '{status: ST_DONE, is_clique: 1'b0, set_size: size_v};
			default:  res_v = '{status: ST_DONE, is_clique: 1'b0, set_size: size_v};
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		sts.clr_last   = &clr_q;
		sts.out_free   = !out_valid_q || out_ready;
		sts.is_load    = (in_data.func == FUNC_LOAD);
		sts.in_range   = (32'(in_data.vert_a) < 32'(NUM_VERTICES))
		              && (32'(in_data.vert_b) < 32'(NUM_VERTICES))
		              && (32'(in_data.vert_c) < 32'(NUM_VERTICES));
		sts.store_full = (total_q == CW'(MAX_TRIPLES));
		sts.is_last    = in_data.last;
		sts.list_over  = list_full || ovf_q;
		sts.set_small  = (n_q < NW'(2));
		sts.bkt_ok     = rng_q && (pw_cnt != '0);
		sts.l_lt_m     = (l_q < m_q);
		sts.hit        = (store_rdata == ck_q);
		sts.k_last     = (k_p1 == n_q);
		sts.j_more     = ((j_q + NW'(2)) < n_q);
		sts.i_more     = ((i_q + NW'(3)) < n_q);
	end

endmodule

[rtl/core/hypergraph_clique_check.sv]
// Top level of the three-uniform hypergraph clique check block.
//
//   Channel   Direction  Handshake            Payload
//   in        input      in_valid/in_ready    in_data (in_t): func, vert_a..c, last
//   out       output     out_valid/out_ready  out_data (out_t): status, is_clique, set_size
//
// After reset the pair table is swept to zero, one entry a cycle, with in_ready low. A push
// or dropped triple is taken in S_IDLE; a stored one also passes S_LOAD_WR for the pair
// table read-modify-write, as its read data is registered. A final candidate runs the
// bucket scan: S_CK_START to S_CK_BKT fetch the first pair's bucket, S_CK_LI onward that
// of a new first vertex, S_CK_PAIR onward any other; S_CK_RK and S_CK_SCAN check stored and
// later list vertices. in_ready is low while a result sits unclaimed with out_ready low.
`include "hypergraph_clique_check_macros.svh"

module hypergraph_clique_check
	import hcc_pkg::*;
#(
	parameter int NUM_VERTICES = 64,
	parameter int MAX_TRIPLES  = 4096,
	parameter int MAX_SET      = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	cmd_t cmd;
	sts_t sts;

	hcc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	hcc_dpath #(
		.NUM_VERTICES(NUM_VERTICES),
		.MAX_TRIPLES (MAX_TRIPLES),
		.MAX_SET     (MAX_SET)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data (out_data),
		.cmd      (cmd),
		.sts      (sts)
	);

	`HCC_ASSERT_IMP(a_held_result_blocks_input, out_valid && !out_ready, !in_ready, "input taken while a result is held")
	`HCC_ASSERT_NXT(a_push_gives_no_result, in_valid && in_ready && (in_data.func == FUNC_PUSH) && !in_data.last, !out_valid, "push without last produced a result")
	`HCC_ASSERT_IMP(a_clique_only_when_done, out_valid && out_data.is_clique, out_data.status == ST_DONE, "clique flag on a non-check result")
	`HCC_ASSERT_IMP(a_drop_is_empty, out_valid && (out_data.status == ST_DROP), !out_data.is_clique && (out_data.set_size == '0), "dropped-triple result carries data")

endmodule
